FILE: hdl/htp_pkg.sv
package htp_pkg;

  localparam int unsigned BLINK_PERIOD_MS_DEF = 2000;
  localparam int unsigned TICK_MS_DEF         = 10;

  localparam logic [5:0] SET_MIN     = 6'd31;
  localparam logic [5:0] SET_MAX     = 6'd41;
  localparam logic [5:0] SET_START   = 6'd35;
  localparam logic [5:0] TEMP_OFFSET = 6'd28;
  localparam logic [5:0] LEDS_ALL    = 6'h3f;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef struct packed {
    logic       down_button;
    logic       up_button;
    logic [3:0] temp_gray;
    logic       power_switch;
  } in_item_t;

  typedef struct packed {
    logic [5:0] temp_leds;
    logic       heater_on;
    logic       power_led;
  } out_item_t;

  function automatic logic [3:0] gray_decode(input logic [3:0] g);
    logic [3:0] b;
    b[3] = g[3];
    b[2] = b[3] ^ g[2];
    b[1] = b[2] ^ g[1];
    b[0] = b[1] ^ g[0];
    return b;
  endfunction

  function automatic logic [5:0] set_pattern(input logic [3:0] idx);
    logic [5:0] p;
    unique case (idx)
      4'd0:    p = 6'h01;
      4'd1:    p = 6'h03;
      4'd2:    p = 6'h02;
      4'd3:    p = 6'h06;
      4'd4:    p = 6'h04;
      4'd5:    p = 6'h0c;
      4'd6:    p = 6'h08;
      4'd7:    p = 6'h18;
      4'd8:    p = 6'h10;
      4'd9:    p = 6'h30;
      4'd10:   p = 6'h20;
      default: p = 6'h00;
    endcase
    return p;
  endfunction

endpackage

FILE: hdl/htp_core.sv
module htp_core #(
  parameter int unsigned BLINK_PERIOD_MS = htp_pkg::BLINK_PERIOD_MS_DEF,
  parameter int unsigned TICK_MS         = htp_pkg::TICK_MS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  htp_pkg::in_item_t   item,
  output htp_pkg::out_item_t  result
);
  import htp_pkg::*;

  localparam int unsigned CNT_MAX = BLINK_PERIOD_MS + TICK_MS;
  localparam int unsigned CW      = $clog2(CNT_MAX + 1);
  localparam int unsigned QUARTER = BLINK_PERIOD_MS / 4;
  localparam int unsigned PW      = $clog2(QUARTER);
  localparam int unsigned SW      = $clog2(2 * QUARTER);
  localparam int unsigned PH_STEP = TICK_MS % QUARTER;

  localparam logic [CW-1:0] PERIOD_C = CW'(BLINK_PERIOD_MS);
  localparam logic [CW-1:0] HALF_C   = CW'(BLINK_PERIOD_MS / 2);
  localparam logic [CW-1:0] TICK_C   = CW'(TICK_MS);
  localparam logic [SW-1:0] EIGHTH_C = SW'(BLINK_PERIOD_MS / 8);
  localparam logic [SW-1:0] QUART_C  = SW'(QUARTER);
  localparam logic [SW-1:0] PHSTEP_C = SW'(PH_STEP);

  logic          prev_power_r, prev_power_nxt;
  logic          prev_up_r, prev_up_nxt;
  logic          prev_down_r, prev_down_nxt;
  logic [5:0]    setpoint_r, setpoint_nxt;
  logic [CW-1:0] blink_r, blink_nxt;
  logic [PW-1:0] phase_r, phase_nxt;

  logic          clr;
  logic [CW-1:0] blink0;
  logic [SW-1:0] phase0;
  logic [SW-1:0] phase_sum;
  logic [5:0]    sp0;
  logic [5:0]    sp1;
  logic [5:0]    sp2;
  logic [3:0]    dec;
  logic [5:0]    meas;
  logic [5:0]    pat;
  logic [5:0]    sp_idx;
  logic          heat;
  logic [5:0]    leds;

  always_comb begin
    clr    = (blink_r > PERIOD_C) || (item.power_switch && !prev_power_r);
    blink0 = clr ? '0 : blink_r;
    phase0 = clr ? '0 : SW'(phase_r);
    sp0    = (item.power_switch && !prev_power_r) ? SET_START : setpoint_r;
    dec    = gray_decode(item.temp_gray);
    meas   = {2'b00, dec} + TEMP_OFFSET;
    sp1    = sp0;
    sp2    = sp0;
    heat   = 1'b0;
    leds   = '0;
    pat    = '0;
    sp_idx = '0;
    if (item.power_switch) begin
      if (dec != 4'd0) begin
        if (sp0 > SET_MIN && item.down_button && !prev_down_r) begin
          sp1 = sp0 - 6'd1;
        end
        sp2 = sp1;
        if (sp1 < SET_MAX && item.up_button && !prev_up_r) begin
          sp2 = sp1 + 6'd1;
        end
        heat   = meas < sp2;
        sp_idx = sp2 - SET_MIN;
        pat    = set_pattern(sp_idx[3:0]);
        if (sp2 >= SET_MIN && sp2 <= SET_MAX) begin
          if (meas == sp2 || phase0 < EIGHTH_C) begin
            leds = pat;
          end
        end
      end else begin
        leds = (blink0 < HALF_C) ? LEDS_ALL : 6'h00;
      end
    end
    phase_sum      = phase0 + PHSTEP_C;
    phase_nxt      = (phase_sum >= QUART_C) ? PW'(phase_sum - QUART_C) : PW'(phase_sum);
    blink_nxt      = blink0 + TICK_C;
    setpoint_nxt   = sp2;
    prev_power_nxt = item.power_switch;
    prev_up_nxt    = item.up_button;
    prev_down_nxt  = item.down_button;

    result.power_led = item.power_switch;
    result.heater_on = heat;
    result.temp_leds = leds;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_power_r <= 1'b0;
      prev_up_r    <= 1'b0;
      prev_down_r  <= 1'b0;
      setpoint_r   <= '0;
      blink_r      <= '0;
      phase_r      <= '0;
    end else if (step) begin
      prev_power_r <= prev_power_nxt;
      prev_up_r    <= prev_up_nxt;
      prev_down_r  <= prev_down_nxt;
      setpoint_r   <= setpoint_nxt;
      blink_r      <= blink_nxt;
      phase_r      <= phase_nxt;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    SW'(phase_r) < QUART_C)
    else $error("blink phase out of range");

  a_blink_range: assert property (@(posedge clk) disable iff (!rst_n)
    blink_r <= CW'(CNT_MAX))
    else $error("blink counter out of range");

  a_sp_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (setpoint_r >= SET_MIN && setpoint_r <= SET_MAX)
      |=> (setpoint_r >= SET_MIN && setpoint_r <= SET_MAX))
    else $error("setpoint left its range");

  a_no_heat_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.temp_gray == 4'd0) |-> !result.heater_on)
    else $error("heater on during sensor fault");

endmodule

FILE: hdl/heater_thermostat_panel_unit.sv
// Thermostat panel: one input word per 10 ms tick, one result word per tick.
// Input channel in_*: tdata carries the switch, Gray sensor code and buttons.
// Result channel out_*: tdata carries the power LED, heater drive and the six
// setpoint LEDs. There is no configuration port.
// A word taken at the input handshake is registered in the input register,
// then, when the pipeline advances, evaluated against the setpoint and blink
// state and loaded into the result register, which raises out_tvalid; a
// stall on the result channel can hold it in the input register meanwhile.
// Throughput is one word per cycle while out_tready is high; the input and
// result registers form a two-stage pipeline that advances when the input
// register holds a word and the result register is empty or being taken.
// When out_tready is low the result is held and the input register fills;
// in_tready drops only when both stages are full.
// Reset (rst_n low, synchronous) empties both stages, clears the switch and
// button history, the setpoint and the blink counter.
module heater_thermostat_panel_unit #(
  parameter int unsigned BLINK_PERIOD_MS = htp_pkg::BLINK_PERIOD_MS_DEF,
  parameter int unsigned TICK_MS         = htp_pkg::TICK_MS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // power_switch[0], temp_gray[4:1], up_button[5], down_button[6], zero[7]
  input  logic [htp_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // power_led[0], heater_on[1], temp_leds[7:2]
  output logic [htp_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import htp_pkg::*;

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t result;
  logic      advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_item_t'(in_tdata[6:0]);
    end
  end

  htp_core #(
    .BLINK_PERIOD_MS(BLINK_PERIOD_MS),
    .TICK_MS        (TICK_MS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;

  a_heat_needs_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_item_r.heater_on || out_item_r.power_led))
    else $error("heater on while power off");

  a_leds_need_power: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.power_led) |-> (out_item_r.temp_leds == 6'h00))
    else $error("leds lit while power off");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result lost after advance");

endmodule
